[rtl/pf_pkg.sv]
// Shared types and constants for the Playfair digraph cipher.
`default_nettype none

package pf_pkg;

   localparam int unsigned LETTER_W = 5;
   localparam int unsigned SQ_DIM   = 5;
   localparam int unsigned ROW_W    = LETTER_W * SQ_DIM;
   localparam int unsigned POS_W    = 3;
   localparam int unsigned CELL_W   = 5;
   localparam int unsigned CSR_IDX_W = 3;

   localparam logic [LETTER_W-1:0] CODE_I = 5'd8;
   localparam logic [LETTER_W-1:0] CODE_J = 5'd9;
   localparam logic [LETTER_W-1:0] CODE_X = 5'd23;
   localparam logic [LETTER_W-1:0] CODE_Y = 5'd24;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW0 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW4 = 3'd5;

   // Reset square ABCDE / FGHIK / LMNOP / QRSTU / VWXYZ.
   localparam logic [ROW_W-1:0] RESET_ROW0 = 25'd4294688;
   localparam logic [ROW_W-1:0] RESET_ROW1 = 25'd10755269;
   localparam logic [ROW_W-1:0] RESET_ROW2 = 25'd16201099;
   localparam logic [ROW_W-1:0] RESET_ROW3 = 25'd21613104;
   localparam logic [ROW_W-1:0] RESET_ROW4 = 25'd27025109;

   typedef logic [SQ_DIM-1:0][ROW_W-1:0]          rows_type;
   typedef logic [SQ_DIM*SQ_DIM-1:0][LETTER_W-1:0] cells_type;

   typedef struct packed {
      logic [LETTER_W-1:0] first;
      logic [LETTER_W-1:0] second;
      logic                last;
   } digraph_type;

endpackage

`default_nettype wire

[rtl/playfair_digraph_cipher.sv]
// Playfair digraph cipher: letter pairing, filler insertion and square lookup.
//
// Usage:
//   req_* carries one letter per transfer; req_tlast marks the final letter
//   of a message. rsp_* carries one ciphered digraph per transfer; rsp_tlast
//   marks the final digraph. csr_* writes the mode (index 0) and the five key
//   square rows (indexes 1..5); write it only while the block is idle.
// Path: a digraph completed by a letter goes into the pairing register at the
//   letter transfer, then into the result register as a ciphered digraph once
//   that register is free, with the square lookup between the two registers.
// Throughput: one letter per cycle while the result register is free. A
//   letter that yields two digraphs (a doubled final pair in encrypt mode)
//   holds req_tready low until the first digraph drains to the result register.
// Reset: encrypt mode, the standard square ABCDE/FGHIK/LMNOP/QRSTU/VWXYZ, no
//   letter held, both pipeline registers empty.
// Stall: when rsp_tready is low the result register holds; the pairing
//   register holds its digraphs and req_tready drops once nothing can move.
`default_nettype none

module playfair_digraph_cipher (
   input  wire logic        clock,
   input  wire logic        reset,
   // letter channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [4:0] letter_in, [7:5] zero
   input  wire logic        req_tlast,   // end_of_text
   // digraph channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [4:0] first_letter, [9:5] second_letter, [15:10] zero
   output logic             rsp_tlast,   // last_pair
   // configuration
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [24:0] csr_data
);

   localparam int unsigned LW = pf_pkg::LETTER_W;
   localparam int unsigned PW = pf_pkg::POS_W;

   // configuration registers
   logic               mode_ff;
   pf_pkg::rows_type   rows_ff;
   pf_pkg::cells_type  cells;

   // pairing state
   logic [LW-1:0]      held_letter_ff, held_letter_in;
   logic               held_valid_ff, held_valid_in;

   // pairing register: up to two raw digraphs
   logic [1:0]           pend_cnt_ff, pend_cnt_in;
   pf_pkg::digraph_type  slot0_ff, slot0_in;
   pf_pkg::digraph_type  slot1_ff, slot1_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   pf_pkg::digraph_type  rsp_ff, rsp_in;

   logic                 req_xfer;
   logic                 out_free;
   logic                 drain;
   logic [LW-1:0]        letter;
   pf_pkg::digraph_type  new0, new1;
   logic [1:0]           new_cnt;
   logic [2:0]           row_sel;

   assign cells = rows_ff;

   // Filler for a lone letter: X, or Y when the letter is X.
   function automatic logic [LW-1:0] filler_for(input logic [LW-1:0] l);
      return (l == pf_pkg::CODE_X) ? pf_pkg::CODE_Y : pf_pkg::CODE_X;
   endfunction

   function automatic logic [PW-1:0] inc5(input logic [PW-1:0] p);
      return (p == PW'(pf_pkg::SQ_DIM - 1)) ? '0 : p + PW'(1);
   endfunction

   function automatic logic [PW-1:0] dec5(input logic [PW-1:0] p);
      return (p == '0) ? PW'(pf_pkg::SQ_DIM - 1) : p - PW'(1);
   endfunction

   function automatic logic [LW-1:0] cell_at(input pf_pkg::cells_type sq,
                                             input logic [PW-1:0] r,
                                             input logic [PW-1:0] c);
      logic [4:0] idx;
      idx = {2'b00, r} * 5'(pf_pkg::SQ_DIM) + {2'b00, c};
      return sq[idx];
   endfunction

   // Find a letter; the last match in row-major order wins, a miss gives 0,0.
   function automatic logic [2*PW-1:0] locate(input pf_pkg::cells_type sq,
                                              input logic [LW-1:0] l);
      logic [PW-1:0] r;
      logic [PW-1:0] c;
      r = '0;
      c = '0;
      for (int i = 0; i < int'(pf_pkg::SQ_DIM); i++) begin
         for (int j = 0; j < int'(pf_pkg::SQ_DIM); j++) begin
            if (sq[5'(i * int'(pf_pkg::SQ_DIM) + j)] == l) begin
               r = PW'(i);
               c = PW'(j);
            end
         end
      end
      return {r, c};
   endfunction

   function automatic pf_pkg::digraph_type cipher(input pf_pkg::cells_type sq,
                                                  input logic dec,
                                                  input pf_pkg::digraph_type d);
      logic [PW-1:0] r1, c1, r2, c2;
      pf_pkg::digraph_type o;
      {r1, c1} = locate(sq, d.first);
      {r2, c2} = locate(sq, d.second);
      o.last = d.last;
      if (r1 == r2) begin
         o.first  = cell_at(sq, r1, dec ? dec5(c1) : inc5(c1));
         o.second = cell_at(sq, r2, dec ? dec5(c2) : inc5(c2));
      end else if (c1 == c2) begin
         o.first  = cell_at(sq, dec ? dec5(r1) : inc5(r1), c1);
         o.second = cell_at(sq, dec ? dec5(r2) : inc5(r2), c2);
      end else begin
         o.first  = cell_at(sq, r1, c2);
         o.second = cell_at(sq, r2, c1);
      end
      return o;
   endfunction

   // Handshakes: the pairing register takes a letter when it is empty or
   // its single digraph moves to the result register in the same cycle.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign drain      = (pend_cnt_ff != 2'd0) && out_free;
   assign req_tready = (pend_cnt_ff == 2'd0) || ((pend_cnt_ff == 2'd1) && out_free);
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Pair the incoming letter with the held one.
   always_comb begin
      letter = req_tdata[LW-1:0];
      if (!mode_ff && letter == pf_pkg::CODE_J) begin
         letter = pf_pkg::CODE_I;
      end
      new0           = '{first: held_letter_ff, second: letter, last: req_tlast};
      new1           = '{first: letter, second: filler_for(letter), last: 1'b1};
      new_cnt        = 2'd0;
      held_letter_in = held_letter_ff;
      held_valid_in  = held_valid_ff;
      if (held_valid_ff) begin
         if (!mode_ff && letter == held_letter_ff) begin
            // doubled letter: split it with filler
            new0 = '{first: held_letter_ff, second: filler_for(held_letter_ff),
                     last: 1'b0};
            if (req_tlast) begin
               new_cnt        = 2'd2;
               held_valid_in  = 1'b0;
               held_letter_in = '0;
            end else begin
               new_cnt        = 2'd1;
               held_letter_in = letter;
            end
         end else begin
            new_cnt        = 2'd1;
            held_valid_in  = 1'b0;
            held_letter_in = '0;
         end
      end else if (req_tlast) begin
         // odd final letter: pad it
         new0    = new1;
         new_cnt = 2'd1;
      end else begin
         held_letter_in = letter;
         held_valid_in  = 1'b1;
      end
   end

   // Pairing register and result register next values.
   always_comb begin
      pend_cnt_in  = pend_cnt_ff;
      slot0_in     = slot0_ff;
      slot1_in     = slot1_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_free) begin
         rsp_valid_in = (pend_cnt_ff != 2'd0);
         rsp_in       = cipher(cells, mode_ff, slot0_ff);
      end
      if (req_xfer) begin
         // any pending digraph has drained this cycle
         pend_cnt_in = new_cnt;
         slot0_in    = new0;
         slot1_in    = new1;
      end else if (drain) begin
         pend_cnt_in = pend_cnt_ff - 2'd1;
         slot0_in    = slot1_ff;
      end
   end

   assign row_sel = csr_index - pf_pkg::CSR_ROW0;

   // Control and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= 1'b0;
         rows_ff[0]     <= pf_pkg::RESET_ROW0;
         rows_ff[1]     <= pf_pkg::RESET_ROW1;
         rows_ff[2]     <= pf_pkg::RESET_ROW2;
         rows_ff[3]     <= pf_pkg::RESET_ROW3;
         rows_ff[4]     <= pf_pkg::RESET_ROW4;
         held_letter_ff <= '0;
         held_valid_ff  <= 1'b0;
         pend_cnt_ff    <= 2'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == pf_pkg::CSR_MODE) begin
               mode_ff <= csr_data[0];
            end else if (csr_index >= pf_pkg::CSR_ROW0 && csr_index <= pf_pkg::CSR_ROW4) begin
               rows_ff[row_sel] <= csr_data;
            end
         end
         if (req_xfer) begin
            held_letter_ff <= held_letter_in;
            held_valid_ff  <= held_valid_in;
         end
         pend_cnt_ff  <= pend_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_ff.second, rsp_ff.first};
   assign rsp_tlast  = rsp_ff.last;

`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      pend_cnt_ff != 2'd3)
      else $error("pairing register count out of range");

   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      pend_cnt_ff == 2'd2 |-> !req_tready)
      else $error("letter taken while two digraphs pending");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_tlast |=> !held_valid_ff)
      else $error("letter still held after end of text");

   a_drain_moves: assert property (@(posedge clock) disable iff (reset)
      pend_cnt_ff != 2'd0 && out_free |=> rsp_valid_ff)
      else $error("pending digraph did not reach the result register");
`endif

endmodule

`default_nettype wire
